@@ hdl/apt_pkg.sv @@
// Package with shared types, codes and sizes of the address patch table.
package apt_pkg;

    localparam int PATCH_ENTRIES = 256;
    localparam int IDX_W = $clog2(PATCH_ENTRIES);
    localparam int CNT_W = $clog2(PATCH_ENTRIES + 1);
    localparam int ID_W = 8;
    localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;
    localparam int ADDR_W = 32;
    localparam int VALUE_W = 64;
    localparam int GEN_W = 32;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        REQ_REGISTER    = 3'd0,
        REQ_SET_ENABLE  = 3'd1,
        REQ_QUERY       = 3'd2,
        REQ_LOOKUP_BC   = 3'd3,
        REQ_LOOKUP_WORD = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_BRANCH = 2'd1,
        KIND_CALL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ENTRY,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic               reached;
        logic               enable;
        logic [1:0]         kind;
    } entry_t;

    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [2:0]         code;
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic               enable;
        logic [ID_W-1:0]    id;
    } patch_req_t;

    typedef struct packed {
        status_t            status;
        logic               hit;
        logic [VALUE_W-1:0] value;
        logic [ID_W-1:0]    id;
        logic               enabled;
        logic               reached;
    } result_t;

endpackage

@@ hdl/apt_table.sv @@
// Entry table with one write port and one registered read port: one write and one registered read per cycle.
module apt_table
    import apt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output entry_t   rd_data
);

    entry_t mem [PATCH_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/apt_match.sv @@
// Shared match unit: compare one table entry against the lookup key.
module apt_match
    import apt_pkg::*;
(
    input  entry_t            ent,
    input  logic [ADDR_W-1:0] addr,
    input  logic              word_lookup,
    output logic              match
);

    logic kind_ok;

    always_comb
    begin
        // kind three matches neither class
        if (word_lookup)
        begin
            kind_ok = (ent.kind == KIND_WORD);
        end
        else
        begin
            kind_ok = (ent.kind == KIND_BRANCH) || (ent.kind == KIND_CALL);
        end
        match = ent.enable && kind_ok && (ent.addr == addr);
    end

endmodule

@@ hdl/apt_ctrl.sv @@
// Request sequencer: decode, entry read-modify-write and the lookup scan.
module apt_ctrl
    import apt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  patch_req_t req_in,
    input  logic       lookups_active,
    input  entry_t     rd_data,
    output mem_req_t   mem_req,
    output logic       busy,
    output logic       done,
    output result_t    res,
    output logic [GEN_W-1:0] generation
);

    state_t           state_reg, state_next;
    patch_req_t       req_reg, req_next;
    result_t          res_reg, res_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [GEN_W-1:0] gen_reg, gen_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             chk_valid_reg, chk_valid_next;
    idx_t             chk_idx_reg, chk_idx_next;
    logic             word_lookup;
    logic             match;
    entry_t           upd_entry;

    assign word_lookup = (req_reg.code == REQ_LOOKUP_WORD);

    apt_match u_match (
        .ent         (rd_data),
        .addr        (req_reg.addr),
        .word_lookup (word_lookup),
        .match       (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            gen_reg       <= GEN_W'(1);
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            gen_reg       <= gen_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        chk_idx_reg <= chk_idx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        done_next      = 1'b0;
        count_next     = count_reg;
        gen_next       = gen_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        mem_req        = '0;
        upd_entry      = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_in;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next = '0;
                unique case (req_code_t'(req_reg.code)) inside
                    REQ_REGISTER:
                    begin
                        if (count_reg == CNT_W'(PATCH_ENTRIES))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_req.wr_en           = 1'b1;
                            mem_req.wr_addr         = IDX_W'(count_reg);
                            mem_req.wr_data.addr    = req_reg.addr;
                            mem_req.wr_data.value   = req_reg.value;
                            mem_req.wr_data.reached = 1'b0;
                            mem_req.wr_data.enable  = req_reg.enable;
                            mem_req.wr_data.kind    = req_reg.kind;
                            count_next  = count_reg + CNT_W'(1);
                            gen_next    = gen_reg + GEN_W'(1);
                            res_next.id = ID_W'(count_reg);
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end

                    REQ_SET_ENABLE, REQ_QUERY:
                    begin
                        if (CMP_W'(req_reg.id) < CMP_W'(count_reg))
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = IDX_W'(req_reg.id);
                            state_next      = S_ENTRY;
                        end
                        else
                        begin
                            res_next.status = ST_BAD_ID;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end

                    REQ_LOOKUP_BC, REQ_LOOKUP_WORD:
                    begin
                        if (lookups_active && (count_reg != '0))
                        begin
                            issue_next = count_reg;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_ENTRY:
            begin
                // entry data arrived from the table
                if (req_reg.code == REQ_QUERY)
                begin
                    res_next.enabled = rd_data.enable;
                    res_next.reached = rd_data.reached;
                end
                else if (rd_data.enable != req_reg.enable)
                begin
                    upd_entry.enable = req_reg.enable;
                    mem_req.wr_en    = 1'b1;
                    mem_req.wr_addr  = IDX_W'(req_reg.id);
                    mem_req.wr_data  = upd_entry;
                    gen_next         = gen_reg + GEN_W'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                // issue reads from the highest id down, check one per cycle
                if (chk_valid_reg && match)
                begin
                    upd_entry.reached = 1'b1;
                    mem_req.wr_en     = 1'b1;
                    mem_req.wr_addr   = chk_idx_reg;
                    mem_req.wr_data   = upd_entry;
                    res_next.hit      = 1'b1;
                    res_next.id       = ID_W'(chk_idx_reg);
                    if (word_lookup)
                    begin
                        res_next.value = {32'd0, rd_data.value[31:0]};
                    end
                    else
                    begin
                        res_next.value = rd_data.value;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (issue_reg != '0)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(issue_reg - CNT_W'(1));
                    issue_next      = issue_reg - CNT_W'(1);
                    chk_valid_next  = 1'b1;
                    chk_idx_next    = IDX_W'(issue_reg - CNT_W'(1));
                end
                else
                begin
                    // nothing left to check: miss
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign res        = res_reg;
    assign generation = gen_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PATCH_ENTRIES))
        else $error("entry count above table size");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.hit |-> res_reg.status == ST_DONE)
        else $error("hit reported with error status");

    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != $past(gen_reg) |-> gen_reg == $past(gen_reg) + GEN_W'(1))
        else $error("generation moved by more than one");

    a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !chk_valid_reg)
        else $error("scan check pending while idle");
`endif

endmodule

@@ hdl/address_patch_table_unit.sv @@
// Top level of the address patch table: config register, sequencer and table.
//
// Usage:
//   Requests enter on start with req_type, patch_kind, address, patch_value,
//   enable_bit and patch_id; a request is taken at a clock edge where start is
//   high and busy is low. busy stays high until the request is finished.
//   Each request gives exactly one result, shown on status, hit, result_value,
//   result_id, entry_enabled, entry_reached and generation for one cycle
//   while done is high. The receiver cannot stall: take the result that cycle.
//   Register and unknown requests finish after decode; set enable and query
//   also read the entry (not for a bad id); a lookup scans the entries. The
//   single read port of the entry table, walked one entry per cycle from the
//   highest id down, sets the lookup time; a lookup stops at the first
//   enabled match. A new request may be taken in the cycle done is shown.
//   Configuration: cfg_data (lookups_active) is written when cfg_valid and
//   cfg_ready are both high; write it only while no request is in flight.
//   Reset: rst_n clears the entry count, sets generation to one and turns
//   lookups off. Table contents are not cleared; only ids below the entry
//   count are ever read, so no clearing pass is needed.
module address_patch_table_unit
    import apt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [1:0]         patch_kind,
    input  logic [ADDR_W-1:0]  address,
    input  logic [VALUE_W-1:0] patch_value,
    input  logic               enable_bit,
    input  logic [ID_W-1:0]    patch_id,
    output logic               done,
    output logic [1:0]         status,
    output logic               hit,
    output logic [VALUE_W-1:0] result_value,
    output logic [ID_W-1:0]    result_id,
    output logic               entry_enabled,
    output logic               entry_reached,
    output logic [GEN_W-1:0]   generation,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    logic       lookups_active_reg;
    patch_req_t req_in;
    mem_req_t   mem_req;
    entry_t     rd_data;
    result_t    res;

    // Hold the lookup enable; take writes only between requests.
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookups_active_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lookups_active_reg <= cfg_data;
        end
    end

    // Bundle the request fields for the sequencer.
    always_comb
    begin
        req_in.code   = req_type;
        req_in.kind   = patch_kind;
        req_in.addr   = address;
        req_in.value  = patch_value;
        req_in.enable = enable_bit;
        req_in.id     = patch_id;
    end

    apt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .req_in         (req_in),
        .lookups_active (lookups_active_reg),
        .rd_data        (rd_data),
        .mem_req        (mem_req),
        .busy           (busy),
        .done           (done),
        .res            (res),
        .generation     (generation)
    );

    apt_table u_table (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Drive the result ports from the registered result.
    assign status        = res.status;
    assign hit           = res.hit;
    assign result_value  = res.value;
    assign result_id     = res.id;
    assign entry_enabled = res.enabled;
    assign entry_reached = res.reached;

endmodule
